// File: hw/rtl/pshd_pkg.sv
// pshd_pkg: types, codes and helpers for the pulse shape hit digitizer
// used by pulse_shape_hit_digitizer; depends on nothing else
`default_nettype none

package pshd_pkg;

  // item modes
  localparam logic [1:0] MODE_LOAD    = 2'd0;
  localparam logic [1:0] MODE_DEPOSIT = 2'd1;
  localparam logic [1:0] MODE_EMIT    = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_SAMPLE_INTERVAL  = 2'd0;
  localparam logic [1:0] REG_INVERSE_INTERVAL = 2'd1;
  localparam logic [1:0] REG_NUM_SAMPLES      = 2'd2;

  // configuration reset values
  localparam logic [15:0] RST_SAMPLE_INTERVAL  = 16'd6400;
  localparam logic [15:0] RST_INVERSE_INTERVAL = 16'd2621;
  localparam logic [5:0]  RST_NUM_SAMPLES      = 6'd30;

  // 40 bit amplitude limits
  localparam logic signed [39:0] AMP_MAX = 40'sh7F_FFFF_FFFF;
  localparam logic signed [39:0] AMP_MIN = 40'sh80_0000_0000;

  // input word
  typedef struct packed {
    logic [1:0]         mode;
    logic [4:0]         table_index;
    logic signed [23:0] shape_value;
    logic signed [23:0] slope_value;
    logic [23:0]        deposit_energy;
    logic signed [19:0] deposit_time;
    logic [63:0]        cell_key;
  } pshd_in_t;

  // result word
  typedef struct packed {
    logic [63:0]        cell_out;
    logic [4:0]         sample_number;
    logic signed [39:0] amplitude;
    logic               last_sample;
  } pshd_out_t;

  // clamp a 42 bit value into the 40 bit amplitude range
  function automatic logic signed [39:0] sat40(input logic signed [41:0] v);
    logic signed [41:0] hi;
    logic signed [41:0] lo;
    hi = {{2{AMP_MAX[39]}}, AMP_MAX};
    lo = {{2{AMP_MIN[39]}}, AMP_MIN};
    if (v > hi) begin
      return AMP_MAX;
    end else if (v < lo) begin
      return AMP_MIN;
    end
    return v[39:0];
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/pulse_shape_hit_digitizer.sv
// pulse_shape_hit_digitizer: top level, sequencer around one shared multiplier
// depends on pshd_pkg
//
//   channel  direction  handshake              word
//   in_      input      in_valid / in_stall    pshd_in_t
//   out_     output     out_valid / out_stall  pshd_out_t
//   cfg_     input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// a table load or an unused mode stays idle; a deposit runs S_P, S_K, S_DT1, S_DT2,
// then, unless the window is empty, S_RD and per sample in it S_M1, S_TERM, S_M2 and
// S_ACC, since the one 37x25 multiplier is used twice per sample; an emit runs S_ERD,
// then S_EOUT per sample, held by out_stall. in_stall is high in reset and while an
// item is being worked on; cfg_ready is high only when idle with no result waiting.
// rst_n is synchronous and clears the accumulator valid bits, so no clearing pass.
`default_nettype none

module pulse_shape_hit_digitizer
  import pshd_pkg::*;
#(
  parameter int MAX_SAMPLES = 32
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire pshd_in_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output pshd_out_t      out_data,
  input  wire logic      cfg_valid,
  output logic           cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int CW = $clog2(MAX_SAMPLES + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_P, S_K, S_DT1, S_DT2, S_RD, S_M1, S_TERM, S_M2, S_ACC, S_ERD, S_EOUT
  } state_t;

  state_t state_r;

  // configuration
  logic [15:0] interval_r;
  logic [15:0] inverse_r;
  logic [5:0]  num_r;

  // working registers
  pshd_in_t           in_r;
  logic signed [12:0] k_r;
  logic signed [28:0] dt_r;
  logic signed [36:0] term_r;
  logic signed [61:0] prod_r;
  logic [CW-1:0]      i_r;
  logic [CW-1:0]      j_r;
  logic [MAX_SAMPLES-1:0] sv_r;

  // result register
  logic      out_valid_r;
  pshd_out_t out_r;

  // memories and their registered read data
  logic signed [23:0] shape_mem [MAX_SAMPLES];
  logic signed [23:0] slope_mem [MAX_SAMPLES];
  logic signed [39:0] sum_mem [MAX_SAMPLES];
  logic signed [23:0] shape_rd_r;
  logic signed [23:0] slope_rd_r;
  logic signed [39:0] sum_rd_r;
  logic               rdv_r;

  logic in_acc;
  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = !rst_n || (state_r != S_IDLE);
  assign cfg_ready = rst_n && (state_r == S_IDLE) && !out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // effective sample count
  logic [6:0]    num7;
  logic [6:0]    n_full;
  logic [CW-1:0] n_eff;
  logic [CW-1:0] n_last;
  always_comb begin
    num7 = {1'b0, num_r};
    if (num_r == 6'd0) begin
      n_full = 7'd1;
    end else if (num7 > 7'(MAX_SAMPLES)) begin
      n_full = 7'(MAX_SAMPLES);
    end else begin
      n_full = num7;
    end
  end
  assign n_eff  = n_full[CW-1:0];
  assign n_last = n_eff - CW'(1);

  logic at_end;
  assign at_end = (i_r == n_last) || (j_r == n_last);

  // shared multiplier operand selection
  logic signed [36:0] mul_a;
  logic signed [24:0] mul_b;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_P: begin
        mul_a = {{17{in_r.deposit_time[19]}}, in_r.deposit_time};
        mul_b = {9'd0, inverse_r};
      end
      S_DT1: begin
        mul_a = {{24{k_r[12]}}, k_r};
        mul_b = {9'd0, interval_r};
      end
      S_M1: begin
        mul_a = {{8{dt_r[28]}}, dt_r};
        mul_b = {slope_rd_r[23], slope_rd_r};
      end
      S_M2: begin
        mul_a = term_r;
        mul_b = {1'b0, in_r.deposit_energy};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // shift rounding, ties to even
  logic [23:0]        p_frac;
  logic               round_up;
  logic signed [12:0] k_nxt;
  always_comb begin
    p_frac   = prod_r[23:0];
    round_up = (p_frac > 24'h80_0000) || ((p_frac == 24'h80_0000) && prod_r[24]);
    k_nxt    = prod_r[36:24] + {12'd0, round_up};
  end

  // residual and sample window
  logic signed [29:0] dt_full;
  logic signed [13:0] k14;
  logic signed [13:0] kneg;
  logic signed [13:0] n14;
  logic               win_empty;
  always_comb begin
    dt_full   = {{10{in_r.deposit_time[19]}}, in_r.deposit_time} - prod_r[29:0];
    k14       = {k_r[12], k_r};
    kneg      = -k14;
    n14       = {7'd0, n_full};
    win_empty = (k14 >= n14) || (kneg >= n14);
  end

  // first order shape term, rounded half up to Q.24
  logic signed [52:0] shape_ext;
  logic signed [52:0] term_full;
  logic signed [52:0] term_rnd;
  always_comb begin
    shape_ext = {{13{shape_rd_r[23]}}, shape_rd_r, 16'd0};
    term_full = shape_ext - prod_r[52:0];
    term_rnd  = term_full + 53'sd32768;
  end

  // contribution and saturating accumulate
  logic signed [61:0] c_rnd;
  logic signed [39:0] contrib;
  logic signed [39:0] sum_old;
  logic signed [41:0] sum_wide;
  logic signed [39:0] sum_new;
  always_comb begin
    c_rnd    = prod_r + 62'sd524288;
    contrib  = sat40(c_rnd[61:20]);
    sum_old  = rdv_r ? sum_rd_r : '0;
    sum_wide = {{2{sum_old[39]}}, sum_old} + {{2{contrib[39]}}, contrib};
    sum_new  = sat40(sum_wide);
  end

  // emit hand-off into the result register
  logic out_free;
  logic emit_load;
  logic emit_done;
  assign out_free  = !out_valid_r || !out_stall;
  assign emit_load = (state_r == S_EOUT) && out_free;
  assign emit_done = emit_load && (i_r == n_last);

  logic [CW+4:0] i_wide;
  assign i_wide = (CW+5)'(i_r);

  // memory addressing
  logic          sum_re;
  logic          tab_re;
  logic          sum_we;
  logic [CW-1:0] i_next;
  logic [CW-1:0] j_next;
  logic [AW-1:0] sum_ra;
  logic [AW-1:0] tab_ra;
  logic [AW-1:0] sum_wa;
  always_comb begin
    i_next = i_r + CW'(1);
    j_next = j_r + CW'(1);
    sum_we = (state_r == S_ACC);
    sum_re = (state_r == S_RD) || (state_r == S_ERD) ||
             ((state_r == S_ACC) && !at_end) || (emit_load && !emit_done);
    tab_re = (state_r == S_RD) || ((state_r == S_ACC) && !at_end);
    if ((state_r == S_ACC) || (state_r == S_EOUT)) begin
      sum_ra = i_next[AW-1:0];
      tab_ra = j_next[AW-1:0];
    end else begin
      sum_ra = i_r[AW-1:0];
      tab_ra = j_r[AW-1:0];
    end
    sum_wa = i_r[AW-1:0];
  end

  // table load at the accepting edge
  logic          tab_we;
  logic [AW+4:0] idx_wide;
  assign idx_wide = (AW+5)'(in_data.table_index);
  assign tab_we   = in_acc && (in_data.mode == MODE_LOAD) &&
                    ({2'd0, in_data.table_index} < 7'(MAX_SAMPLES));

  // shape and slope tables
  always_ff @(posedge clk) begin
    if (tab_we) begin
      shape_mem[idx_wide[AW-1:0]] <= in_data.shape_value;
      slope_mem[idx_wide[AW-1:0]] <= in_data.slope_value;
    end
    if (tab_re) begin
      shape_rd_r <= shape_mem[tab_ra];
      slope_rd_r <= slope_mem[tab_ra];
    end
  end

  // accumulator memory
  always_ff @(posedge clk) begin
    if (sum_we) begin
      sum_mem[sum_wa] <= sum_new;
    end
    if (sum_re) begin
      sum_rd_r <= sum_mem[sum_ra];
    end
  end

  // sequencer, configuration and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      interval_r  <= RST_SAMPLE_INTERVAL;
      inverse_r   <= RST_INVERSE_INTERVAL;
      num_r       <= RST_NUM_SAMPLES;
      sv_r        <= '0;
      rdv_r       <= 1'b0;
      out_valid_r <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
    end else begin
      prod_r <= mul_a * mul_b;

      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_SAMPLE_INTERVAL) begin
          interval_r <= cfg_data;
        end else if (cfg_index == REG_INVERSE_INTERVAL) begin
          inverse_r <= cfg_data;
        end else if (cfg_index == REG_NUM_SAMPLES) begin
          num_r <= cfg_data[5:0];
        end
      end

      if (sum_re) begin
        rdv_r <= sv_r[sum_ra];
      end

      // a word taken downstream frees the register unless the next one moves in
      if (out_valid_r && !out_stall && !emit_load) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            in_r <= in_data;
            if (in_data.mode == MODE_DEPOSIT) begin
              state_r <= S_P;
            end else if (in_data.mode == MODE_EMIT) begin
              i_r     <= '0;
              state_r <= S_ERD;
            end
          end
        end
        S_P: begin
          state_r <= S_K;
        end
        S_K: begin
          k_r     <= k_nxt;
          state_r <= S_DT1;
        end
        S_DT1: begin
          state_r <= S_DT2;
        end
        S_DT2: begin
          dt_r <= dt_full[28:0];
          i_r  <= k_r[12] ? '0 : k14[CW-1:0];
          j_r  <= k_r[12] ? kneg[CW-1:0] : '0;
          state_r <= win_empty ? S_IDLE : S_RD;
        end
        S_RD: begin
          state_r <= S_M1;
        end
        S_M1: begin
          state_r <= S_TERM;
        end
        S_TERM: begin
          term_r  <= term_rnd[52:16];
          state_r <= S_M2;
        end
        S_M2: begin
          state_r <= S_ACC;
        end
        S_ACC: begin
          sv_r[i_r[AW-1:0]] <= 1'b1;
          if (at_end) begin
            state_r <= S_IDLE;
          end else begin
            i_r     <= i_next;
            j_r     <= j_next;
            state_r <= S_M1;
          end
        end
        S_ERD: begin
          state_r <= S_EOUT;
        end
        S_EOUT: begin
          if (emit_load) begin
            out_valid_r         <= 1'b1;
            out_r.cell_out      <= in_r.cell_key;
            out_r.sample_number <= i_wide[4:0];
            out_r.amplitude     <= rdv_r ? sum_rd_r : '0;
            out_r.last_sample   <= emit_done;
            if (emit_done) begin
              sv_r    <= '0;
              state_r <= S_IDLE;
            end else begin
              i_r <= i_next;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // a result appears only out of the emit sequence
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EOUT))
    else $error("result raised outside emit");

  // an emit leaves every accumulator cleared
  assert property (@(posedge clk) disable iff (!rst_n)
    emit_done |=> (sv_r == '0))
    else $error("accumulators not cleared after emit");

  // sample and table index stay apart by the shift
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_M1) |->
      (($signed({1'b0, i_r}) - $signed({1'b0, j_r})) == (CW+1)'(k_r)))
    else $error("sample and table index out of step");

  // both indexes stay inside the pulse
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_M1) |-> ((i_r < n_eff) && (j_r < n_eff)))
    else $error("index outside pulse window");

  // the last flag marks the final sample number
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.last_sample) |-> (out_r.sample_number == 5'((CW+5)'(n_last))))
    else $error("last flag on wrong sample");

endmodule

`default_nettype wire

// File: dv/tb_top.sv
// tb_top: self-checking bench for pulse_shape_hit_digitizer, with a fixed-point
// digitizer model, random idling and stalls, and a table of directed words
// depends on pshd_pkg and the pulse_shape_hit_digitizer rtl
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import pshd_pkg::*;

  localparam logic [1:0] MODE_UNUSED    = 2'd3;
  localparam int         TABLE_DEPTH    = 32;
  localparam int         SETTLE_CYCLES  = 200;
  localparam int         HOLD_CYCLES    = 400;
  localparam int         WATCHDOG_LIMIT = 4000;
  localparam int         PHASE_ITEMS    = 20;
  localparam int         STEADY_ITEMS   = 14;
  localparam int         NUM_PHASES     = 5;
  localparam int         IDLE_PCT       = 28;
  localparam longint     HALF24         = 64'sd8388608;
  localparam int         TIME_MAX       = 524287;
  localparam int         TIME_MIN       = -524288;

  typedef enum logic {ROW_WORD, ROW_SETUP} row_kind_t;

  // an amplitude typed into the table overrides the model for a whole pulse
  typedef struct packed {
    logic               typed;
    logic signed [39:0] amp;
  } word_note_t;

  typedef struct packed {
    row_kind_t  kind;
    pshd_in_t   word;
    word_note_t note;
    logic [15:0] interval;
    logic [15:0] inverse;
    logic [15:0] samples;
  } stim_row_t;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  pshd_in_t    in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  pshd_out_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data  = '0;

  pulse_shape_hit_digitizer dut (.*);

  // model state and its copy of the registers
  longint      shape_mem  [TABLE_DEPTH];
  longint      slope_mem  [TABLE_DEPTH];
  longint      pulse_sums [TABLE_DEPTH];
  logic [15:0] interval_reg = RST_SAMPLE_INTERVAL;
  logic [15:0] inverse_reg  = RST_INVERSE_INTERVAL;
  logic [5:0]  samples_reg  = RST_NUM_SAMPLES;

  pshd_out_t   pulse_q [$];
  word_note_t  typed_q [$];
  stim_row_t   directed_rows [$];
  int          errors       = 0;
  int          idle_cycles  = 0;
  bit          steady       = 1'b0;
  bit          holdoff_go   = 1'b0;
  bit          holdoff_done = 1'b0;

  // 10 ns clock
  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint clamp40(longint v);
    if (v > longint'(AMP_MAX)) return longint'(AMP_MAX);
    if (v < longint'(AMP_MIN)) return longint'(AMP_MIN);
    return v;
  endfunction

  // zero means one sample, anything past the table means all of it
  function automatic int active_samples();
    if (samples_reg == 6'd0) return 1;
    if (samples_reg > 6'(TABLE_DEPTH)) return TABLE_DEPTH;
    return int'(samples_reg);
  endfunction

  // apply one accepted word and queue the pulse samples it releases
  task automatic digitize(input pshd_in_t w, input word_note_t note);
    int        n;
    longint    t;
    longint    p;
    longint    k;
    longint    r;
    longint    dt;
    longint    e;
    longint    j;
    longint    term;
    longint    contrib;
    pshd_out_t res;
    n = active_samples();
    case (w.mode)
      MODE_LOAD: begin
        shape_mem[w.table_index] = longint'($signed(w.shape_value));
        slope_mem[w.table_index] = longint'($signed(w.slope_value));
      end
      MODE_DEPOSIT: begin
        e = longint'({40'd0, w.deposit_energy});
        t = longint'($signed(w.deposit_time));
        // whole-sample shift, rounded to nearest with ties to even
        p = t * longint'({48'd0, inverse_reg});
        k = p >>> 24;
        r = p - (k <<< 24);
        if (r > HALF24 || (r == HALF24 && k[0])) k = k + 1;
        dt = t - k * longint'({48'd0, interval_reg});
        for (int i = 0; i < n; i++) begin
          j = i - k;
          if (j >= 0 && j < n) begin
            term = shape_mem[j] * 64'sd65536 - dt * slope_mem[j];
            term = (term + 64'sd32768) >>> 16;
            contrib = (term * e + 64'sd524288) >>> 20;
            pulse_sums[i] = clamp40(pulse_sums[i] + clamp40(contrib));
          end
        end
      end
      MODE_EMIT: begin
        for (int i = 0; i < n; i++) begin
          res.cell_out      = w.cell_key;
          res.sample_number = 5'(i);
          res.amplitude     = note.typed ? note.amp : pulse_sums[i][39:0];
          res.last_sample   = (i == n - 1);
          pulse_q = {pulse_q, res};
        end
        foreach (pulse_sums[m]) pulse_sums[m] = 0;
      end
      default: ;
    endcase
  endtask

  task automatic check_sample(input pshd_out_t got);
    pshd_out_t want;
    if (pulse_q.size() == 0) begin
      $error("unexpected result word: cell_out %h sample_number %0d",
             got.cell_out, got.sample_number);
      errors++;
      return;
    end
    want = pulse_q.pop_front();
    if (got.cell_out !== want.cell_out) begin
      $error("cell_out: expected %h, got %h", want.cell_out, got.cell_out);
      errors++;
    end
    if (got.sample_number !== want.sample_number) begin
      $error("sample_number: expected %0d, got %0d", want.sample_number, got.sample_number);
      errors++;
    end
    if (got.amplitude !== want.amplitude) begin
      $error("amplitude: expected %0d, got %0d", want.amplitude, got.amplitude);
      errors++;
    end
    if (got.last_sample !== want.last_sample) begin
      $error("last_sample: expected %0b, got %0b", want.last_sample, got.last_sample);
      errors++;
    end
  endtask

  // monitor: results first, then register writes, then the accepted input word
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) check_sample(out_data);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SAMPLE_INTERVAL:  interval_reg = cfg_data;
          REG_INVERSE_INTERVAL: inverse_reg = cfg_data;
          REG_NUM_SAMPLES:      samples_reg = cfg_data[5:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (typed_q.size() == 0) begin
          $error("input word accepted with nothing offered");
          errors++;
        end else begin
          digitize(in_data, typed_q.pop_front());
        end
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: random stalls, one long hold-off, none in the steady stretch
  initial begin
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (holdoff_go && !holdoff_done) begin
        holdoff_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= (!steady && $urandom_range(99) < IDLE_PCT);
    end
  end

  function automatic pshd_in_t rand_word(logic [1:0] mode);
    pshd_in_t w;
    w.mode           = mode;
    w.table_index    = 5'($urandom);
    w.shape_value    = 24'($urandom);
    w.slope_value    = 24'($urandom);
    w.deposit_energy = 24'($urandom);
    w.deposit_time   = 20'($urandom);
    w.cell_key       = {$urandom, $urandom};
    return w;
  endfunction

  function automatic pshd_in_t load_word(logic [4:0] idx, logic [23:0] shape,
                                         logic [23:0] slope);
    pshd_in_t w;
    w = rand_word(MODE_LOAD);
    w.table_index = idx;
    w.shape_value = shape;
    w.slope_value = slope;
    return w;
  endfunction

  function automatic pshd_in_t deposit_word(logic [23:0] energy, logic [19:0] t);
    pshd_in_t w;
    w = rand_word(MODE_DEPOSIT);
    w.deposit_energy = energy;
    w.deposit_time   = t;
    return w;
  endfunction

  function automatic pshd_in_t emit_word(logic [63:0] key);
    pshd_in_t w;
    w = rand_word(MODE_EMIT);
    w.cell_key = key;
    return w;
  endfunction

  // deposits mostly land near a sample inside or just outside the window
  function automatic pshd_in_t random_deposit();
    pshd_in_t w;
    int       roll;
    int       ival;
    int       k;
    int       t;
    w = rand_word(MODE_DEPOSIT);
    roll = $urandom_range(99);
    if (roll < 10) w.deposit_energy = '1;
    else if (roll < 15) w.deposit_energy = '0;
    if ($urandom_range(99) < 85) begin
      ival = int'(interval_reg);
      k = int'($urandom_range(active_samples() + 3)) - 2;
      t = k * ival + int'($urandom_range(ival)) - ival / 2;
      if (t > TIME_MAX) t = TIME_MAX;
      if (t < TIME_MIN) t = TIME_MIN;
      w.deposit_time = 20'(t);
    end
    return w;
  endfunction

  function automatic stim_row_t word_row(pshd_in_t w, logic typed, logic signed [39:0] amp);
    stim_row_t row;
    row = '0;
    row.kind = ROW_WORD;
    row.word = w;
    row.note.typed = typed;
    row.note.amp = amp;
    return row;
  endfunction

  function automatic stim_row_t setup_row(logic [15:0] iv, logic [15:0] inv, logic [15:0] ns);
    stim_row_t row;
    row = '0;
    row.kind = ROW_SETUP;
    row.interval = iv;
    row.inverse = inv;
    row.samples = ns;
    return row;
  endfunction

  // append one row to the directed table
  function automatic void add_row(stim_row_t row);
    directed_rows = {directed_rows, row};
  endfunction

  // offer one word after a random gap and hold it until accepted
  task automatic send_word(input pshd_in_t w, input word_note_t note);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    typed_q = {typed_q, note};
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
  endtask

  // stop offering and wait for every expected sample to come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pulse_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // registers change only once the block has gone quiet
  task automatic apply_setup(input logic [15:0] iv, input logic [15:0] inv,
                             input logic [15:0] ns);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(REG_SAMPLE_INTERVAL, iv);
    write_reg(REG_INVERSE_INTERVAL, inv);
    write_reg(REG_NUM_SAMPLES, ns);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int          count;
    int          roll;
    pshd_in_t    w;
    word_note_t  plain;
    logic [15:0] ival;
    plain = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill both tables so that no deposit reads an unwritten entry
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      send_word(load_word(5'(i), 24'($urandom), 24'($urandom)), plain);
    end

    // directed words, reset settings first
    add_row(word_row(emit_word(64'd0), 1'b1, 40'sd0));
    add_row(word_row(deposit_word('1, 20'h7FFFF), 1'b0, 40'sd0));
    add_row(word_row(deposit_word('1, 20'h80000), 1'b0, 40'sd0));
    add_row(word_row(deposit_word('0, 20'd100), 1'b0, 40'sd0));
    add_row(word_row(emit_word('1), 1'b1, 40'sd0));
    add_row(word_row(deposit_word('1, 20'd0), 1'b0, 40'sd0));
    add_row(word_row(deposit_word('1, 20'hFFFFF), 1'b0, 40'sd0));
    add_row(word_row(deposit_word(24'($urandom), 20'd19300), 1'b0, 40'sd0));
    add_row(word_row(rand_word(MODE_UNUSED), 1'b0, 40'sd0));
    add_row(word_row(emit_word({$urandom, $urandom}), 1'b0, 40'sd0));
    add_row(word_row(emit_word({$urandom, $urandom}), 1'b1, 40'sd0));
    add_row(word_row(load_word(5'd31, 24'h7FFFFF, 24'h800000), 1'b0, 40'sd0));
    add_row(word_row(load_word(5'd0, 24'h800000, 24'h7FFFFF), 1'b0, 40'sd0));
    add_row(word_row(deposit_word('1, 20'd50), 1'b0, 40'sd0));
    add_row(word_row(emit_word({$urandom, $urandom}), 1'b0, 40'sd0));
    // exact halves of a sample: ties go to the even shift
    add_row(setup_row(16'd512, 16'd32768, 16'd32));
    add_row(word_row(deposit_word('1, 20'd256), 1'b0, 40'sd0));
    add_row(word_row(deposit_word('1, 20'd768), 1'b0, 40'sd0));
    add_row(word_row(deposit_word('1, 20'(-256)), 1'b0, 40'sd0));
    add_row(word_row(emit_word({$urandom, $urandom}), 1'b0, 40'sd0));
    // zero inverse interval, sample count of zero
    add_row(setup_row(16'hFFFF, 16'd0, 16'd0));
    add_row(word_row(deposit_word('1, 20'h80000), 1'b0, 40'sd0));
    add_row(word_row(emit_word({$urandom, $urandom}), 1'b0, 40'sd0));
    // zero sample interval, sample count past the table
    add_row(setup_row(16'd0, 16'hFFFF, 16'd63));
    add_row(word_row(deposit_word(24'($urandom), 20'd7000), 1'b0, 40'sd0));
    add_row(word_row(deposit_word(24'($urandom), 20'(-1000)), 1'b0, 40'sd0));
    add_row(word_row(emit_word({$urandom, $urandom}), 1'b0, 40'sd0));
    // lowest settings
    add_row(setup_row(16'd1, 16'd1, 16'd1));
    add_row(word_row(deposit_word('1, 20'h7FFFF), 1'b0, 40'sd0));
    add_row(word_row(emit_word({$urandom, $urandom}), 1'b0, 40'sd0));

    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_SETUP) begin
        apply_setup(directed_rows[r].interval, directed_rows[r].inverse,
                    directed_rows[r].samples);
      end else begin
        send_word(directed_rows[r].word, directed_rows[r].note);
      end
    end

    // random phases, each under its own settings
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: apply_setup(RST_SAMPLE_INTERVAL, RST_INVERSE_INTERVAL, 16'(RST_NUM_SAMPLES));
        1: begin
          ival = 16'($urandom_range(65535, 257));
          apply_setup(ival, 16'((32'h100_0000 + ival / 2) / ival),
                      16'($urandom_range(32, 1)));
        end
        2: apply_setup(RST_SAMPLE_INTERVAL, RST_INVERSE_INTERVAL, 16'd32);
        3: apply_setup(16'hFFFF, 16'd256, 16'($urandom_range(4, 1)));
        default: apply_setup(16'($urandom_range(256, 1)), 16'hFFFF,
                             16'($urandom_range(32, 1)));
      endcase
      count = 0;
      while (count < PHASE_ITEMS) begin
        steady = (ph == 2 && count < STEADY_ITEMS);
        // receiver holds off while two pulses are asked for back to back
        if (ph == 1 && count == 8 && !holdoff_go) begin
          holdoff_go = 1'b1;
          send_word(emit_word({$urandom, $urandom}), plain);
          send_word(emit_word({$urandom, $urandom}), plain);
        end
        // sender pauses until every sample has come out
        if (ph == 2 && count == STEADY_ITEMS) wait_drained();
        roll = $urandom_range(99);
        if (roll < 18) w = rand_word(MODE_LOAD);
        else if (roll < 72) w = random_deposit();
        else if (roll < 94) w = rand_word(MODE_EMIT);
        else w = rand_word(MODE_UNUSED);
        send_word(w, plain);
        if (w.mode != MODE_UNUSED) count++;
      end
    end
    steady = 1'b0;

    // final drain and a quiet tail
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pulse_q.size() != 0) begin
      $error("%0d expected result words never arrived", pulse_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
